FILE: hw/rtl/vn3_pkg.sv
`default_nettype none
package vn3_pkg;

    localparam int DATA_W  = 32;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 31;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] ADDR_MIN_LENGTH = 3'd0;
    localparam logic [DATA_W-1:0] MIN_LENGTH_RST  = 32'd1;

    // Side data that travels with a vector through squaring and root
    typedef struct packed {
        logic                   ok;
        logic [2:0]             neg;
        logic [2:0][DATA_W-1:0] mag;
    } side_t;

    // Control that travels with a vector through the dividers
    typedef struct packed {
        logic              ok;
        logic              uok;
        logic [2:0]        neg;
        logic [ROOT_W-1:0] len;
    } div_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/vector_normalize_3d.sv
`default_nettype none
// Vector length and normalization. Each item is a signed Q16.16 vector
// (x, y, z) with a validity flag; the result is the length in unsigned
// Q16.16 (rounded down) and the unit vector in signed Q2.30 (rounded toward
// zero). A new item is taken every cycle unless the output stalls; the
// path runs through the 32-stage square root (one root bit per stage) and
// the 31-stage dividers (one quotient bit per stage). The whole
// pipeline advances together: it holds only while a finished item waits at
// the output register. Invalid input gives all-zero results with both flags
// low; a length of zero or below min_length (APB register at offset 0,
// reset 1) gives a zero unit vector with unit_ok low.
module vector_normalize_3d (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // APB configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input item
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [31:0]   s_vec_x,
    input  wire logic signed [31:0]   s_vec_y,
    input  wire logic signed [31:0]   s_vec_z,
    input  wire logic                 s_vec_ok,
    // result item
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [31:0]               m_length,
    output logic                      m_length_ok,
    output logic signed [31:0]        m_unit_x,
    output logic signed [31:0]        m_unit_y,
    output logic signed [31:0]        m_unit_z,
    output logic                      m_unit_ok
);
    import vn3_pkg::*;

    logic [DATA_W-1:0] min_length_reg;
    logic              en;

    logic              sq_valid;
    logic [SUM_W-1:0]  sq_sum;
    side_t             sq_side;

    logic              rt_valid;
    logic [ROOT_W-1:0] rt_root;
    side_t             rt_side;

    logic                   chk_valid_reg;
    div_ctrl_t              chk_ctrl_reg;
    logic [2:0][DATA_W-1:0] chk_mag_reg;

    logic                   dv_valid;
    div_ctrl_t              dv_ctrl;
    logic [2:0][QUO_W-1:0]  dv_quo;

    logic                   out_valid_reg;
    logic [ROOT_W-1:0]      out_len_reg;
    logic                   out_len_ok_reg;
    logic [2:0][DATA_W-1:0] out_unit_reg;
    logic                   out_unit_ok_reg;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MIN_LENGTH_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_MIN_LENGTH) begin
            min_length_reg <= pwdata;
        end
    end

    assign prdata = (paddr == ADDR_MIN_LENGTH) ? min_length_reg : '0;

    // Advance the whole pipeline unless a finished item is stuck at the output
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    vn3_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_vec    ({s_vec_z, s_vec_y, s_vec_x}),
        .in_ok     (s_vec_ok),
        .out_valid (sq_valid),
        .out_sum   (sq_sum),
        .out_side  (sq_side)
    );

    vn3_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_rad    (sq_sum),
        .in_side   (sq_side),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // Decide validity of the unit vector against the minimum length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else if (en) begin
            chk_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chk_ctrl_reg.ok  <= rt_side.ok;
            chk_ctrl_reg.uok <= rt_side.ok && (rt_root != '0) && (rt_root >= min_length_reg);
            chk_ctrl_reg.neg <= rt_side.neg;
            chk_ctrl_reg.len <= rt_root;
            chk_mag_reg      <= rt_side.mag;
        end
    end

    vn3_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chk_valid_reg),
        .in_ctrl   (chk_ctrl_reg),
        .in_mag    (chk_mag_reg),
        .out_valid (dv_valid),
        .out_ctrl  (dv_ctrl),
        .out_quo   (dv_quo)
    );

    // Output register: apply signs, zero the fields that are not valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_len_reg     <= dv_ctrl.ok ? dv_ctrl.len : '0;
            out_len_ok_reg  <= dv_ctrl.ok;
            out_unit_ok_reg <= dv_ctrl.uok;
            for (int j = 0; j < 3; j++) begin
                if (!dv_ctrl.uok) begin
                    out_unit_reg[j] <= '0;
                end else if (dv_ctrl.neg[j]) begin
                    out_unit_reg[j] <= DATA_W'(0) - {1'b0, dv_quo[j]};
                end else begin
                    out_unit_reg[j] <= {1'b0, dv_quo[j]};
                end
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_length    = out_len_reg;
    assign m_length_ok = out_len_ok_reg;
    assign m_unit_x    = out_unit_reg[0];
    assign m_unit_y    = out_unit_reg[1];
    assign m_unit_z    = out_unit_reg[2];
    assign m_unit_ok   = out_unit_ok_reg;

`ifndef NO_ASSERTIONS
    a_unit_needs_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unit_ok |-> m_length_ok && m_length != '0)
        else $error("unit vector valid without a valid nonzero length");

    a_bad_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_length_ok |-> m_length == '0)
        else $error("invalid length not zero");

    a_bad_unit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_unit_ok |-> m_unit_x == '0 && m_unit_y == '0 && m_unit_z == '0)
        else $error("invalid unit vector not zero");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/vn3_square.sv
`default_nettype none
module vn3_square (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [2:0][vn3_pkg::DATA_W-1:0] in_vec,
    input  wire logic                          in_ok,
    output logic                               out_valid,
    output logic [vn3_pkg::SUM_W-1:0]          out_sum,
    output vn3_pkg::side_t                     out_side
);
    import vn3_pkg::*;

    logic [2:0]  vld_reg;
    side_t       sa_reg, sb_reg, sc_reg;
    side_t       sa_next;
    logic [2:0][SUM_W-1:0] sq_reg;
    logic [SUM_W-1:0]      sum_reg;

    // Magnitude of each two's complement component
    always_comb begin
        sa_next.ok = in_ok;
        for (int j = 0; j < 3; j++) begin
            sa_next.neg[j] = in_vec[j][DATA_W-1];
            sa_next.mag[j] = in_vec[j][DATA_W-1] ? (DATA_W'(0) - in_vec[j]) : in_vec[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg <= sa_next;
            sb_reg <= sa_reg;
            sc_reg <= sb_reg;
            for (int j = 0; j < 3; j++) begin
                sq_reg[j] <= SUM_W'(sa_reg.mag[j]) * SUM_W'(sa_reg.mag[j]);
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign out_valid = vld_reg[2];
    assign out_sum   = sum_reg;
    assign out_side  = sc_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/vn3_sqrt.sv
`default_nettype none
module vn3_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [vn3_pkg::SUM_W-1:0]  in_rad,
    input  wire vn3_pkg::side_t             in_side,
    output logic                            out_valid,
    output logic [vn3_pkg::ROOT_W-1:0]      out_root,
    output vn3_pkg::side_t                  out_side
);
    import vn3_pkg::*;

    // One root bit per stage
    logic [ROOT_W-1:0] vld_reg;
    logic [ROOT_W+1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    side_t             side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [ROOT_W+1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  rad_in;
        side_t             side_in;
        logic              vld_in;
        logic [ROOT_W+3:0] trial;
        logic [ROOT_W+3:0] sub;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = {rem_in, rad_in[SUM_W-1 -: 2]};
        assign sub   = {2'b00, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (trial >= sub) begin
                    rem_reg[k]  <= (ROOT_W+2)'(trial - sub);
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= (ROOT_W+2)'(trial);
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                rad_reg[k]  <= {rad_in[SUM_W-3:0], 2'b00};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/vn3_div.sv
`default_nettype none
module vn3_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire vn3_pkg::div_ctrl_t              in_ctrl,
    input  wire logic [2:0][vn3_pkg::DATA_W-1:0] in_mag,
    output logic                                 out_valid,
    output vn3_pkg::div_ctrl_t                   out_ctrl,
    output logic [2:0][vn3_pkg::QUO_W-1:0]       out_quo
);
    import vn3_pkg::*;

    // Three restoring divider lanes, one quotient bit per stage.
    // Quotient of (mag << 30) / len fits 31 bits since mag <= len.
    logic [QUO_W-1:0]             vld_reg;
    div_ctrl_t                    ctrl_reg [QUO_W];
    logic [2:0][DATA_W-1:0]       rem_reg  [QUO_W];
    logic [2:0][QUO_W-1:0]        quo_reg  [QUO_W];
    logic [2:0][QUO_W-1:0]        num_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        div_ctrl_t              ctrl_in;
        logic                   vld_in;
        logic [2:0][DATA_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0]  quo_in;
        logic [2:0][QUO_W-1:0]  num_in;

        if (k == 0) begin : g_first
            assign ctrl_in = in_ctrl;
            assign vld_in  = in_valid;
            for (genvar j = 0; j < 3; j++) begin : g_init
                assign rem_in[j] = {1'b0, in_mag[j][DATA_W-1:1]};
                assign quo_in[j] = '0;
                assign num_in[j] = {in_mag[j][0], (QUO_W-1)'(0)};
            end
        end else begin : g_next
            assign ctrl_in = ctrl_reg[k-1];
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign num_in  = num_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [DATA_W:0] trial;
            assign trial = {rem_in[j], num_in[j][QUO_W-1]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (trial >= {1'b0, ctrl_in.len}) begin
                        rem_reg[k][j] <= DATA_W'(trial - {1'b0, ctrl_in.len});
                        quo_reg[k][j] <= {quo_in[j][QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg[k][j] <= DATA_W'(trial);
                        quo_reg[k][j] <= {quo_in[j][QUO_W-2:0], 1'b0};
                    end
                    num_reg[k][j] <= {num_in[j][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctrl_reg[k] <= ctrl_in;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_ctrl  = ctrl_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule
`default_nettype wire
